// File: rtl/lcttl_pkg.sv
// ----------------------------------------------------------------------------
// lcttl_pkg
// shared constants and types of the lru cache with ttl expiry
// ----------------------------------------------------------------------------
package lcttl_pkg;

  localparam int ENTRIES_DEF = 32;

  // command codes
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // configuration register indexes
  localparam logic [7:0] REG_TTL_MS     = 8'd0;
  localparam logic [7:0] REG_TTL_ENABLE = 8'd1;

  localparam int unsigned TTL_MS_RST = 1000;

  // recency update applied on a sweep
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_TOUCH,
    UPD_DROP,
    UPD_STORE
  } upd_mode_t;

endpackage

// File: rtl/lru_cache_with_ttl_top.sv
// ----------------------------------------------------------------------------
// lru_cache_with_ttl_top
// fully associative key cache with lru replacement and age expiry
// ----------------------------------------------------------------------------
// sequence: key scan, fetch, decide, then a rank sweep only when ranks are
//   updated, then the response
// throughput: one transaction at a time; the key scan and the rank sweep each
//   walk the memories one slot per cycle through a single read port
// reset: synchronous active low; clears all valid bits and control state,
//   ttl_ms returns to 1000 and ttl_enable to 1; no clearing pass is needed
module lru_cache_with_ttl_top
  import lcttl_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: command[1:0], key_tag[65:2], path_in[129:66],
  //   encrypted_in[193:130], now_ms[225:194], zero fill above
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [231:0] in_tdata,
  // out_tdata: found[0], path_out[64:1], encrypted_out[128:65], zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_DECIDE,
    S_SWEEP,
    S_RESP
  } state_t;

  state_t state_r;

  // config
  logic [31:0] ttl_ms_r;
  logic        ttl_en_r;

  // current transaction
  logic [1:0]  cmd_r;
  logic [63:0] key_r;
  logic [63:0] path_r;
  logic [63:0] enc_r;
  logic [31:0] now_r;

  // memories: key per slot; path, encrypted handle and stamp per slot
  logic [63:0]  key_mem  [ENTRIES];
  logic [159:0] data_mem [ENTRIES];
  logic [63:0]  key_q;
  logic [159:0] data_q;
  logic [ENTRIES-1:0] valid_r;

  // walk over slots: issue counter and compare/write stage
  logic [CW-1:0] iss_r;
  logic          stg_vld_r;
  logic [AW-1:0] stg_idx_r;

  // scan results
  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  logic [AW-1:0] hit_rank_r;
  logic          free_r;
  logic [AW-1:0] free_idx_r;
  logic [AW-1:0] best_r;
  logic [AW-1:0] evict_idx_r;

  // rank update
  upd_mode_t     upd_mode_r;
  logic [AW-1:0] upd_slot_r;
  logic [AW-1:0] upd_rank_r;
  logic [AW-1:0] rank_q;

  // result
  logic        res_found_r;
  logic [63:0] res_path_r;
  logic [63:0] res_enc_r;
  logic        out_vld_r;
  logic        out_found_r;
  logic [63:0] out_path_r;
  logic [63:0] out_enc_r;

  logic          walk_issue;
  logic [AW-1:0] walk_addr;
  logic          stg_valid;
  logic [31:0]   age;
  logic          fresh;
  logic [AW-1:0] new_slot;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_enc_r, out_path_r, out_found_r};

  // one slot a cycle while scanning or sweeping
  assign walk_issue = (state_r == S_SCAN || state_r == S_SWEEP) && (iss_r < CNT_END);
  assign walk_addr  = iss_r[AW-1:0];
  assign stg_valid  = valid_r[stg_idx_r];

  // age is the wrapping difference of the 32-bit millisecond clock
  assign age      = now_r - data_q[31:0];
  assign fresh    = !ttl_en_r || (age < ttl_ms_r);
  assign new_slot = free_r ? free_idx_r : evict_idx_r;

  lcttl_recency #(
    .ENTRIES (ENTRIES)
  ) u_recency (
    .clk      (clk),
    .rd_en    (walk_issue),
    .rd_addr  (walk_addr),
    .rd_rank  (rank_q),
    .wr_en    (state_r == S_SWEEP && stg_vld_r),
    .wr_idx   (stg_idx_r),
    .wr_valid (stg_valid),
    .mode     (upd_mode_r),
    .slot     (upd_slot_r),
    .rank     (upd_rank_r)
  );

  // memory ports
  always_ff @(posedge clk) begin
    if (walk_issue) begin
      key_q <= key_mem[walk_addr];
    end
    if (state_r == S_FETCH) begin
      data_q <= data_mem[hit_idx_r];
    end
    if (state_r == S_DECIDE && cmd_r == CMD_STORE && !hit_r) begin
      key_mem[new_slot]  <= key_r;
      data_mem[new_slot] <= {enc_r, path_r, now_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ttl_ms_r   <= TTL_MS_RST;
      ttl_en_r   <= 1'b1;
      valid_r    <= '0;
      out_vld_r  <= 1'b0;
      stg_vld_r  <= 1'b0;
      iss_r      <= '0;
      upd_mode_r <= UPD_NONE;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TTL_MS:     ttl_ms_r <= cfg_data;
          REG_TTL_ENABLE: ttl_en_r <= cfg_data[0];
          default: ;
        endcase
      end

      // the response state reloads the output register itself
      if (out_vld_r && out_tready && state_r != S_RESP) begin
        out_vld_r <= 1'b0;
      end

      if (walk_issue) begin
        iss_r     <= iss_r + CW'(1);
        stg_idx_r <= walk_addr;
        stg_vld_r <= 1'b1;
      end else begin
        stg_vld_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r       <= in_tdata[1:0];
            key_r       <= in_tdata[65:2];
            path_r      <= in_tdata[129:66];
            enc_r       <= in_tdata[193:130];
            now_r       <= in_tdata[225:194];
            iss_r       <= '0;
            hit_r       <= 1'b0;
            hit_idx_r   <= '0;
            free_r      <= 1'b0;
            best_r      <= '0;
            evict_idx_r <= '0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stg_vld_r) begin
            if (stg_valid && key_q == key_r && !hit_r) begin
              hit_r      <= 1'b1;
              hit_idx_r  <= stg_idx_r;
              hit_rank_r <= rank_q;
            end
            // lowest free slot
            if (!stg_valid && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= stg_idx_r;
            end
            // least recent slot, first of the highest rank
            if (stg_valid && rank_q > best_r) begin
              best_r      <= rank_q;
              evict_idx_r <= stg_idx_r;
            end
            if (stg_idx_r == LAST_IDX) begin
              state_r <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          res_found_r <= 1'b0;
          res_path_r  <= '0;
          res_enc_r   <= '0;
          upd_mode_r  <= UPD_NONE;
          upd_slot_r  <= hit_idx_r;
          upd_rank_r  <= hit_rank_r;
          iss_r       <= '0;
          state_r     <= S_RESP;
          case (cmd_r)
            CMD_LOOKUP: begin
              if (hit_r) begin
                state_r <= S_SWEEP;
                if (fresh) begin
                  res_found_r <= 1'b1;
                  res_path_r  <= data_q[95:32];
                  res_enc_r   <= data_q[159:96];
                  upd_mode_r  <= UPD_TOUCH;
                end else begin
                  // stale hit: drop it
                  valid_r[hit_idx_r] <= 1'b0;
                  upd_mode_r         <= UPD_DROP;
                end
              end
            end
            CMD_STORE: begin
              if (!hit_r) begin
                valid_r[new_slot] <= 1'b1;
                upd_slot_r        <= new_slot;
                upd_mode_r        <= UPD_STORE;
                state_r           <= S_SWEEP;
              end
            end
            CMD_REMOVE: begin
              if (hit_r) begin
                valid_r[hit_idx_r] <= 1'b0;
                upd_mode_r         <= UPD_DROP;
                state_r            <= S_SWEEP;
              end
            end
            default: ;
          endcase
        end
        S_SWEEP: begin
          if (stg_vld_r && stg_idx_r == LAST_IDX) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_vld_r || out_tready) begin
            out_vld_r   <= 1'b1;
            out_found_r <= res_found_r;
            out_path_r  <= res_path_r;
            out_enc_r   <= res_enc_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/lcttl_recency.sv
// ----------------------------------------------------------------------------
// lcttl_recency
// recency rank memory with read-modify-write rank update
// ----------------------------------------------------------------------------
module lcttl_recency
  import lcttl_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic [$clog2(ENTRIES)-1:0] rd_rank,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_idx,
  input  logic                       wr_valid,
  input  upd_mode_t                  mode,
  input  logic [$clog2(ENTRIES)-1:0] slot,
  input  logic [$clog2(ENTRIES)-1:0] rank
);

  localparam int AW = $clog2(ENTRIES);

  logic [AW-1:0] rec_mem [ENTRIES];
  logic [AW-1:0] rank_r;
  logic [AW-1:0] rank_nxt;

  assign rd_rank = rank_r;

  // old rank of an invalid slot counts as zero
  always_comb begin
    logic [AW-1:0] old;
    old      = wr_valid ? rank_r : '0;
    rank_nxt = old;
    unique case (mode)
      UPD_TOUCH: begin
        if (wr_idx == slot) begin
          rank_nxt = '0;
        end else if (wr_valid && old < rank) begin
          rank_nxt = old + AW'(1);
        end
      end
      UPD_DROP: begin
        if (wr_valid && old > rank) begin
          rank_nxt = old - AW'(1);
        end
      end
      UPD_STORE: begin
        if (wr_idx == slot) begin
          rank_nxt = '0;
        end else if (wr_valid) begin
          rank_nxt = old + AW'(1);
        end
      end
      default: rank_nxt = old;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rank_r <= rec_mem[rd_addr];
    end
    if (wr_en) begin
      rec_mem[wr_idx] <= rank_nxt;
    end
  end

endmodule

// File: bench/lru_cache_with_ttl_checker.sv
// ----------------------------------------------------------------------------
// lru_cache_with_ttl_checker
// watches the command and response streams, predicts each response from a
// behavioral copy of the cache and compares it field by field
// ----------------------------------------------------------------------------
module lru_cache_with_ttl_checker
  import lcttl_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [231:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending,
  output int           hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic [63:0] encrypted;
    logic [63:0] path;
    logic        found;
  } resp_t;

  logic [31:0] ttl_ms_q;
  logic        ttl_en_q;
  logic        vld [ENTRIES];
  logic [63:0] key_m [ENTRIES];
  logic [63:0] path_m [ENTRIES];
  logic [63:0] enc_m [ENTRIES];
  logic [31:0] stamp_m [ENTRIES];
  int unsigned rank_m [ENTRIES];
  // expected responses in order, written at exp_wr and read at exp_rd
  resp_t       exp_fifo [EXP_DEPTH];
  int unsigned exp_wr;
  int unsigned exp_rd;

  function automatic void drop_entry(int s);
    int unsigned r;
    r = rank_m[s];
    vld[s] = 1'b0;
    rank_m[s] = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (vld[i] && rank_m[i] > r) rank_m[i]--;
  endfunction

  function automatic resp_t cache_access(logic [1:0] cmd, logic [63:0] key,
                                         logic [63:0] pth, logic [63:0] enc,
                                         logic [31:0] now);
    resp_t r;
    int s, f;
    int unsigned best, rk;
    logic [31:0] age;
    r = '0;
    s = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (s < 0 && vld[i] && key_m[i] == key) s = i;
    case (cmd)
      CMD_LOOKUP: begin
        if (s >= 0) begin
          age = now - stamp_m[s];
          if (!ttl_en_q || age < ttl_ms_q) begin
            r.found = 1'b1;
            r.path = path_m[s];
            r.encrypted = enc_m[s];
            rk = rank_m[s];
            for (int i = 0; i < ENTRIES; i++)
              if (i != s && vld[i] && rank_m[i] < rk) rank_m[i]++;
            rank_m[s] = 0;
          end else begin
            drop_entry(s);
          end
        end
      end
      CMD_STORE: begin
        if (s < 0) begin
          f = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (f < 0 && !vld[i]) f = i;
          if (f < 0) begin
            best = 0;
            f = 0;
            for (int i = 0; i < ENTRIES; i++)
              if (rank_m[i] > best) begin
                best = rank_m[i];
                f = i;
              end
            drop_entry(f);
          end
          for (int i = 0; i < ENTRIES; i++)
            if (vld[i]) rank_m[i]++;
          vld[f] = 1'b1;
          key_m[f] = key;
          path_m[f] = pth;
          enc_m[f] = enc;
          stamp_m[f] = now;
          rank_m[f] = 0;
        end
      end
      CMD_REMOVE: if (s >= 0) drop_entry(s);
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    resp_t got, exp_r;
    if (!rst_n) begin
      ttl_ms_q <= TTL_MS_RST;
      ttl_en_q <= 1'b1;
      for (int i = 0; i < ENTRIES; i++) begin
        vld[i] = 1'b0;
        rank_m[i] = 0;
      end
      exp_wr = 0;
      exp_rd = 0;
      fail_count <= 0;
      hit_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TTL_MS) ttl_ms_q <= cfg_data;
        else if (cfg_index == REG_TTL_ENABLE) ttl_en_q <= cfg_data[0];
      end
      if (in_tvalid && in_tready) begin
        exp_fifo[exp_wr % EXP_DEPTH] = cache_access(in_tdata[1:0], in_tdata[65:2],
          in_tdata[129:66], in_tdata[193:130], in_tdata[225:194]);
        exp_wr++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[128:0];
        if (exp_wr == exp_rd) begin
          $error("response with nothing expected: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = exp_fifo[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (got.found) hit_count <= hit_count + 1;
          if (got.found !== exp_r.found)
            $error("found: expected %0d actual %0d", exp_r.found, got.found);
          if (got.path !== exp_r.path)
            $error("path_out: expected %h actual %h", exp_r.path, got.path);
          if (got.encrypted !== exp_r.encrypted)
            $error("encrypted_out: expected %h actual %h", exp_r.encrypted,
                   got.encrypted);
          if (out_tdata[135:129] !== '0)
            $error("zero fill: expected %h actual %h", 7'd0, out_tdata[135:129]);
          if (got !== exp_r || out_tdata[135:129] !== '0)
            fail_count <= fail_count + 1;
        end
      end
    end
    pending = int'(exp_wr - exp_rd);
  end
endmodule

// File: bench/lru_cache_with_ttl_top_test.sv
// ----------------------------------------------------------------------------
// lru_cache_with_ttl_top_test
// stimulus and verdict for the lru cache: directed corner cases, then random
// store/lookup/remove and undefined-command traffic over small key pools with several ttl settings
// ----------------------------------------------------------------------------
module lru_cache_with_ttl_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lcttl_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam int LATENCY = 2 * ENTRIES + 5;
  localparam int STALL_LIMIT = 20000;
  // command code with no meaning and a register index with no register
  localparam logic [1:0] CMD_UNDEF = 2'd3;
  localparam logic [7:0] REG_UNUSED = 8'd9;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // command, key_tag, path_in, encrypted_in, now_ms from bit 0 up
  logic [231:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // found, path_out, encrypted_out from bit 0 up
  logic [135:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           fail_count;
  int           pending;
  int           hit_count;
  int           idle_cycles;
  int           sent;
  bit           rx_random;    // receiver may stall
  bit           rx_hold;      // long receiver hold-off requested
  bit           tx_random;    // sender may insert gaps
  logic [31:0]  clock_ms;     // running time stamp

  lru_cache_with_ttl_top #(.ENTRIES(ENTRIES)) i_dut (.*);

  lru_cache_with_ttl_checker #(.ENTRIES(ENTRIES)) i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (rx_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end else if (rx_random && $urandom_range(3) == 0) begin
        n = $urandom_range(9, 1);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic cfg_write(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // let the cache drain before touching registers
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // the block is busy after an accept, so the wait with valid low after each
  // handshake costs nothing
  task automatic send_cmd(logic [1:0] cmd, logic [63:0] key, logic [63:0] pth,
                          logic [63:0] enc, logic [31:0] now);
    if (tx_random && $urandom_range(4) == 0) begin
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, now, enc, pth, key, cmd};
    @(posedge clk iff in_tready);
    in_tvalid <= 1'b0;
    sent++;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // keys from a pool sized around the cache capacity so hits and evictions mix
  task automatic random_phase(int count, int pool);
    logic [1:0] cmd;
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(pool - 1);
      case ($urandom_range(9))
        0, 1, 2, 3: cmd = CMD_LOOKUP;
        4, 5, 6, 7: cmd = CMD_STORE;
        8: cmd = CMD_REMOVE;
        default: cmd = CMD_UNDEF;
      endcase
      clock_ms = clock_ms + $urandom_range(300);
      if ($urandom_range(50) == 0) clock_ms = $urandom;
      send_cmd(cmd, (k[0] ? 64'hFFFF_FFFF_FFFF_FF00 : 64'h0) | 64'(k), rnd64(),
               rnd64(), clock_ms);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rx_random = 1'b0;
    rx_hold = 1'b0;
    tx_random = 1'b0;
    sent = 0;
    clock_ms = 32'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, each command, duplicate store, stale hit, wrap
    send_cmd(CMD_LOOKUP, '0, '0, '0, '0);
    send_cmd(CMD_STORE, '0, '1, '1, '0);
    send_cmd(CMD_STORE, '1, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555, '1);
    send_cmd(CMD_LOOKUP, '1, '0, '0, 32'd500);
    send_cmd(CMD_STORE, '1, '0, '0, 32'd500);   // already present, no change
    send_cmd(CMD_LOOKUP, '1, '1, '1, 32'd998);  // age 999 across wrap, fresh
    send_cmd(CMD_LOOKUP, '0, '0, '0, 32'd999);  // age 999, fresh
    send_cmd(CMD_LOOKUP, '0, '0, '0, 32'd1000); // stale, dropped
    send_cmd(CMD_LOOKUP, '0, '0, '0, 32'd1000);
    send_cmd(CMD_UNDEF, '1, '1, '1, '1);        // undefined command ignored
    send_cmd(CMD_REMOVE, '1, '0, '0, 32'd1000);
    send_cmd(CMD_LOOKUP, '1, '0, '0, 32'd1000);
    send_cmd(CMD_REMOVE, 64'd7, '0, '0, '0);
    // fill past capacity to force an eviction of the oldest key
    for (int i = 0; i <= ENTRIES; i++)
      send_cmd(CMD_STORE, 64'h100 + 64'(i), 64'(i), ~64'(i), 32'd2000);
    send_cmd(CMD_LOOKUP, 64'h100, '0, '0, 32'd2001);
    send_cmd(CMD_LOOKUP, 64'h100 + ENTRIES, '0, '0, 32'd2001);

    // sender pauses until every response is back, then ttl extremes
    settle();
    cfg_write(REG_TTL_MS, 32'd1);
    cfg_write(REG_UNUSED, '1);                  // unused index ignored
    rx_random = 1'b1;
    tx_random = 1'b1;
    random_phase(300, 48);
    settle();
    cfg_write(REG_TTL_MS, '1);
    rx_hold = 1'b1;                             // cache backs up behind the stall
    random_phase(300, 40);
    settle();
    cfg_write(REG_TTL_ENABLE, 32'd0);
    random_phase(300, 64);
    settle();
    cfg_write(REG_TTL_ENABLE, 32'd1);
    cfg_write(REG_TTL_MS, 32'd600);
    random_phase(300, 40);
    settle();
    cfg_write(REG_TTL_MS, 32'd0);               // nothing stays fresh
    random_phase(100, 20);
    settle();
    cfg_write(REG_TTL_MS, 32'd2500);
    rx_random = 1'b0;
    tx_random = 1'b0;
    random_phase(200, 36);

    settle();
    $display("covered %0d commands with %0d hits across six ttl settings,", sent,
             hit_count);
    $display("including eviction, expiry, time wrap and backpressure");
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

// File: sim.f
rtl/lcttl_pkg.sv
rtl/lcttl_recency.sv
rtl/lru_cache_with_ttl_top.sv
bench/lru_cache_with_ttl_checker.sv
bench/lru_cache_with_ttl_top_test.sv
